### rtl/core/csf_pkg.sv
// ----------------------------------------------------------------------------
// csf_pkg
// Types, register indexes and character helpers shared by the caseless
// substring filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package csf_pkg;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam int         NEEDLE_MAX   = 32;
    localparam int         NEEDLE_WORDS = 4;
    localparam int         CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NEEDLE_WORD_0  = 3'd0,
        CFG_NEEDLE_WORD_1  = 3'd1,
        CFG_NEEDLE_WORD_2  = 3'd2,
        CFG_NEEDLE_WORD_3  = 3'd3,
        CFG_NEEDLE_LENGTH  = 3'd4,
        CFG_RESULT_LIMIT   = 3'd5
    } csf_cfg_e;

    typedef struct packed {
        logic [7:0] name_char;
        logic       entry_end;
        logic       list_end;
    } csf_in_t;

    typedef struct packed {
        logic [15:0] entry_index;
        logic [15:0] match_number;
    } csf_out_t;

    typedef struct packed {
        logic [NEEDLE_WORDS-1:0][63:0] words;
        logic [5:0]                    length;
    } csf_needle_t;

    typedef struct packed {
        logic        hit;
        logic        list_end;
        logic [15:0] entry_index;
    } csf_task_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = c - CHAR_UPPER_A + CHAR_LOWER_A;
        end
        return r;
    endfunction

    function automatic logic [7:0] needle_byte(input logic [NEEDLE_WORDS-1:0][63:0] w,
                                               input logic [4:0] i);
        logic [63:0] word;
        word = w[i[4:3]];
        return fold_char(word[{i[2:0], 3'b000} +: 8]);
    endfunction

endpackage

`default_nettype wire

### rtl/core/csf_front.sv
// ----------------------------------------------------------------------------
// csf_front
// Accepts name characters, folds case, keeps the character window and the
// per-entry match flag, and queues one task per finished entry.
// ----------------------------------------------------------------------------
`default_nettype none

module csf_front import csf_pkg::*; #(
    parameter int NAME_SCAN_MAX = 63,
    parameter int INDEX_BITS    = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire csf_in_t     s_data,
    input  wire csf_needle_t needle,
    output logic             q_push,
    output csf_task_t        q_data,
    input  wire logic        q_full
);

    localparam int CP_BITS  = $clog2(NAME_SCAN_MAX + 1);
    localparam int CMP_BITS = (CP_BITS > 6) ? CP_BITS : 6;
    localparam logic [5:0]         NMAX     = 6'(NEEDLE_MAX);
    localparam logic [CP_BITS-1:0] SCAN_END = CP_BITS'(NAME_SCAN_MAX);

    logic [7:0]            win_reg [NEEDLE_MAX];
    logic [7:0]            win_sh  [NEEDLE_MAX];
    logic [CP_BITS-1:0]    cp_reg, cp_next;
    logic                  matched_reg, matched_next;
    logic [INDEX_BITS-1:0] ecnt_reg, ecnt_next;
    logic [5:0]            nl;
    logic                  accept;
    logic                  scan;
    logic                  win_hit;
    logic [CP_BITS-1:0]    cp_inc;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign nl      = (needle.length > NMAX) ? NMAX : needle.length;
    assign scan    = cp_reg < SCAN_END;
    assign cp_inc  = cp_reg + 1'b1;

    always_comb begin
        win_sh[0] = fold_char(s_data.name_char);
        for (int j = 1; j < NEEDLE_MAX; j++) begin
            win_sh[j] = win_reg[j-1];
        end
    end

    always_comb begin
        logic [5:0] idx;
        win_hit = (nl != 6'd0) && (CMP_BITS'(cp_inc) >= CMP_BITS'(nl));
        for (int j = 0; j < NEEDLE_MAX; j++) begin
            idx = nl - 6'(j) - 6'd1;
            if (6'(j) < nl && win_sh[j] != needle_byte(needle.words, idx[4:0])) begin
                win_hit = 1'b0;
            end
        end
    end

    always_comb begin
        cp_next      = cp_reg;
        matched_next = matched_reg;
        ecnt_next    = ecnt_reg;
        q_push       = 1'b0;
        q_data.hit         = 1'b0;
        q_data.list_end    = s_data.list_end;
        q_data.entry_index = 16'(ecnt_reg);
        if (accept) begin
            if (scan) begin
                if (s_data.name_char == 8'd0) begin
                    cp_next = SCAN_END;
                end else begin
                    cp_next = cp_inc;
                    if (win_hit) begin
                        matched_next = 1'b1;
                    end
                end
            end
            if (s_data.entry_end) begin
                q_push       = 1'b1;
                q_data.hit   = (nl == 6'd0) || matched_next;
                cp_next      = '0;
                matched_next = 1'b0;
                ecnt_next    = s_data.list_end ? '0 : ecnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cp_reg      <= '0;
            matched_reg <= 1'b0;
            ecnt_reg    <= '0;
        end else begin
            cp_reg      <= cp_next;
            matched_reg <= matched_next;
            ecnt_reg    <= ecnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && scan && s_data.name_char != 8'd0) begin
            for (int j = 0; j < NEEDLE_MAX; j++) begin
                win_reg[j] <= win_sh[j];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/csf_queue.sv
// ----------------------------------------------------------------------------
// csf_queue
// Short task queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module csf_queue import csf_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire csf_task_t push_data,
    output logic           full,
    input  wire logic      pop,
    output logic           head_valid,
    output csf_task_t      head_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);

    csf_task_t           mem [DEPTH];
    logic [PTR_BITS-1:0] wr_reg, wr_next;
    logic [PTR_BITS-1:0] rd_reg, rd_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full       = cnt_reg == CNT_BITS'(DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_data  = mem[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == LAST) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_next = (rd_reg == LAST) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/csf_back.sv
// ----------------------------------------------------------------------------
// csf_back
// Applies the result limit to queued entry tasks and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module csf_back import csf_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  wire csf_task_t   q_data,
    output logic             q_pop,
    input  wire logic [15:0] result_limit,
    output logic             m_valid,
    input  wire logic        m_ready,
    output csf_out_t         m_data
);

    logic        m_valid_reg, m_valid_next;
    csf_out_t    m_data_reg, m_data_next;
    logic [15:0] rc_reg, rc_next;

    assign q_pop   = q_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        rc_next      = rc_reg;
        if (q_pop) begin
            if (q_data.hit && rc_reg < result_limit) begin
                m_valid_next             = 1'b1;
                m_data_next.entry_index  = q_data.entry_index;
                m_data_next.match_number = rc_reg + 16'd1;
                rc_next                  = rc_reg + 16'd1;
            end
            if (q_data.list_end) begin
                rc_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            rc_reg      <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            rc_reg      <= rc_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

### rtl/core/caseless_substring_filter_top.sv
// ----------------------------------------------------------------------------
// caseless_substring_filter_top
// Case-insensitive substring filter over a stream of entry names.
//
//   Channel   Ports                     Beat
//   input     s_valid s_ready s_data    one name character with end flags
//   result    m_valid m_ready m_data    entry index and match number
//   config    cfg_valid cfg_ready       register index and 64-bit data
//
// One character per cycle; the window compare finishes in the accept cycle.
// A result passes through the queue, then the output register, after its last
// character. The queue of QUEUE_DEPTH entries lets the input run on while
// the result side stalls; s_ready drops only when the queue is full.
// Reset clears control state and all configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module caseless_substring_filter_top import csf_pkg::*; #(
    parameter int NAME_SCAN_MAX = 63,
    parameter int INDEX_BITS    = 16,
    parameter int QUEUE_DEPTH   = 4
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire csf_in_t                 s_data,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output csf_out_t                     m_data,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [63:0]             cfg_data
);

    csf_needle_t needle_reg, needle_next;
    logic [15:0] limit_reg, limit_next;
    csf_task_t   push_data, head_data;
    logic        push, full, pop, head_valid;

    assign cfg_ready = 1'b1;

    always_comb begin
        needle_next = needle_reg;
        limit_next  = limit_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_NEEDLE_WORD_0: needle_next.words[0] = cfg_data;
                CFG_NEEDLE_WORD_1: needle_next.words[1] = cfg_data;
                CFG_NEEDLE_WORD_2: needle_next.words[2] = cfg_data;
                CFG_NEEDLE_WORD_3: needle_next.words[3] = cfg_data;
                CFG_NEEDLE_LENGTH: needle_next.length   = cfg_data[5:0];
                CFG_RESULT_LIMIT:  limit_next           = cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_reg <= '0;
            limit_reg  <= '0;
        end else begin
            needle_reg <= needle_next;
            limit_reg  <= limit_next;
        end
    end

    csf_front #(
        .NAME_SCAN_MAX (NAME_SCAN_MAX),
        .INDEX_BITS    (INDEX_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .needle  (needle_reg),
        .q_push  (push),
        .q_data  (push_data),
        .q_full  (full)
    );

    csf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    csf_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (head_valid),
        .q_data       (head_data),
        .q_pop        (pop),
        .result_limit (limit_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    a_match_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.match_number != 16'd0)
        else $error("result beat with zero match number");

    a_within_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.match_number <= limit_reg)
        else $error("result beat beyond the result limit");

    a_full_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !s_ready)
        else $error("input accepted while task queue is full");

    a_reset_idle: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

### tb/caseless_substring_filter_top_test.sv
// ----------------------------------------------------------------------------
// caseless_substring_filter_top_test
// Self-checking bench for the caseless substring filter. Streams entry names
// one character per beat under a range of needle and limit settings, keeps
// its own scan of the window, match flag and counters, and compares every
// report beat with the predicted entry index and match number. Sender gaps
// and result stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module caseless_substring_filter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import csf_pkg::*;

    localparam int NEEDLE_CAP          = 32;
    localparam int SCAN_CAP            = 63;
    localparam int RANDOM_SETTINGS     = 14;
    localparam int ENTRIES_PER_SETTING = 7;
    localparam int CYCLE_LIMIT         = 1000000;
    localparam int REPORT_WAIT         = 4000;
    localparam int DRAIN_WAIT          = 16;
    localparam int MAX_SHOWN           = 10;
    localparam logic [7:0] CASE_GAP    = CHAR_LOWER_A - CHAR_UPPER_A;
    localparam logic [7:0] LOWER_Z     = CHAR_UPPER_Z + CASE_GAP;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0] idx;
        logic [63:0]             data;
    } reg_write_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    csf_in_t                 s_data    = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    csf_out_t                m_data;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [63:0]             cfg_data  = '0;

    csf_in_t    char_beats[$];
    csf_out_t   match_reports[$];
    reg_write_t reg_writes[$];

    logic [63:0] needle_words [NEEDLE_WORDS] = '{default: '0};
    logic [5:0]  needle_len = '0;
    logic [15:0] result_cap = '0;
    logic [7:0]  recent [NEEDLE_CAP] = '{default: '0};
    int          scan_pos   = 0;
    bit          seen       = 1'b0;
    logic [15:0] entry_no   = '0;
    logic [15:0] reported   = '0;

    logic [7:0] plan_needle [NEEDLE_CAP];
    logic [5:0] plan_len;

    int     send_gap_pct    = 0;
    int     recv_stall_pct  = 0;
    int     fault_count     = 0;
    int     beats_sent      = 0;
    int     reports_checked = 0;
    int     settings_done   = 0;
    longint cycles          = 0;

    caseless_substring_filter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_GAP : c;
    endfunction

    function automatic logic [7:0] needle_char(input int i);
        return to_lower(needle_words[i >> 3][(i & 7) * 8 +: 8]);
    endfunction

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_SHOWN) begin
            $display("[%0t] ERROR: %s", $time, msg);
        end
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [63:0] d);
        case (idx)
            CFG_NEEDLE_WORD_0: needle_words[0] = d;
            CFG_NEEDLE_WORD_1: needle_words[1] = d;
            CFG_NEEDLE_WORD_2: needle_words[2] = d;
            CFG_NEEDLE_WORD_3: needle_words[3] = d;
            CFG_NEEDLE_LENGTH: needle_len = d[5:0];
            CFG_RESULT_LIMIT:  result_cap = d[15:0];
            default: ;
        endcase
    endfunction

    function automatic void scan_beat(input csf_in_t b);
        int       n;
        int       i;
        bit       hit;
        csf_out_t rep;
        n = (needle_len > NEEDLE_CAP) ? NEEDLE_CAP : needle_len;
        if (scan_pos < SCAN_CAP) begin
            if (b.name_char == 8'h00) begin
                scan_pos = SCAN_CAP;
            end else begin
                for (i = NEEDLE_CAP - 1; i > 0; i--) recent[i] = recent[i - 1];
                recent[0] = to_lower(b.name_char);
                scan_pos++;
                if (n > 0 && scan_pos >= n) begin
                    hit = 1'b1;
                    for (i = 0; i < n; i++) begin
                        if (recent[n - 1 - i] != needle_char(i)) hit = 1'b0;
                    end
                    if (hit) seen = 1'b1;
                end
            end
        end
        if (b.entry_end) begin
            if ((n == 0 || seen) && reported < result_cap) begin
                reported++;
                rep.entry_index  = entry_no;
                rep.match_number = reported;
                match_reports.push_back(rep);
            end
            entry_no++;
            scan_pos = 0;
            seen     = 1'b0;
            for (i = 0; i < NEEDLE_CAP; i++) recent[i] = '0;
            if (b.list_end) begin
                entry_no = '0;
                reported = '0;
            end
        end
    endfunction

    always @(posedge aclk) begin : name_driver
        csf_in_t next_beat;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                scan_beat(s_data);
                beats_sent++;
            end
            if (!s_valid || s_ready) begin
                if (char_beats.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    next_beat = char_beats.pop_front();
                    s_data  <= next_beat;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : reg_driver
        reg_write_t next_write;
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                apply_reg(cfg_index, cfg_data);
            end
            if (!cfg_valid || cfg_ready) begin
                if (reg_writes.size() != 0) begin
                    next_write = reg_writes.pop_front();
                    cfg_index <= next_write.idx;
                    cfg_data  <= next_write.data;
                    cfg_valid <= 1'b1;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : report_monitor
        csf_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                reports_checked++;
                if (match_reports.size() == 0) begin
                    note_fault($sformatf("unexpected report: index %0d number %0d",
                                         m_data.entry_index, m_data.match_number));
                end else begin
                    want = match_reports.pop_front();
                    if (m_data.entry_index !== want.entry_index ||
                        m_data.match_number !== want.match_number) begin
                        note_fault($sformatf({"report mismatch: expected index %0d number %0d,",
                                              " got index %0d number %0d"},
                                             want.entry_index, want.match_number,
                                             m_data.entry_index, m_data.match_number));
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] random_letter();
        logic [7:0] c;
        c = CHAR_LOWER_A + 8'($urandom_range(5));
        return $urandom_range(1) ? c - CASE_GAP : c;
    endfunction

    function automatic logic [7:0] mix_case(input logic [7:0] c);
        if (!$urandom_range(1)) return c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return c + CASE_GAP;
        if (c >= CHAR_LOWER_A && c <= LOWER_Z) return c - CASE_GAP;
        return c;
    endfunction

    function automatic logic [7:0] filler(input int n);
        case ($urandom_range(9))
            0, 1, 2, 3: return (n > 0) ? mix_case(plan_needle[$urandom_range(n - 1)])
                                       : random_letter();
            4, 5, 6, 7: return random_letter();
            8:          return 8'($urandom_range(255, 1));
            default:    return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic push_beat(input logic [7:0] c, input bit ee, input bit le);
        csf_in_t b;
        b.name_char = c;
        b.entry_end = ee;
        b.list_end  = le;
        char_beats.push_back(b);
    endtask

    task automatic push_text(input string s, input bit closes_list);
        int i;
        for (i = 0; i < s.len(); i++) begin
            push_beat(s[i], i == s.len() - 1, i == s.len() - 1 && closes_list);
        end
    endtask

    task automatic add_entry(input bit closes_list);
        logic [7:0] name[$];
        int         n;
        int         i;
        int         pad;
        int         pre;
        int         post;
        bit         last;
        n    = (plan_len > NEEDLE_CAP) ? NEEDLE_CAP : plan_len;
        pad  = ($urandom_range(11) == 0) ? 70 : 6;
        pre  = $urandom_range(pad);
        post = $urandom_range(pad);
        for (i = 0; i < pre; i++) name.push_back(filler(n));
        if (n > 0 && $urandom_range(2) != 0) begin
            for (i = 0; i < n; i++) name.push_back(mix_case(plan_needle[i]));
        end
        for (i = 0; i < post; i++) name.push_back(filler(n));
        if (name.size() == 0) name.push_back(filler(n));
        if ($urandom_range(19) == 0) name[$urandom_range(name.size() - 1)] = 8'h00;
        for (i = 0; i < name.size(); i++) begin
            last = (i == name.size() - 1);
            push_beat(name[i], last, last ? closes_list : ($urandom_range(15) == 0));
        end
    endtask

    task automatic write_reg(input csf_cfg_e idx, input logic [63:0] d);
        reg_write_t w;
        w.idx  = idx;
        w.data = d;
        reg_writes.push_back(w);
    endtask

    task automatic load_needle(input logic [15:0] cap, input bit junk);
        logic [63:0] w [NEEDLE_WORDS];
        logic [63:0] len_word;
        logic [63:0] cap_word;
        int          i;
        for (i = 0; i < NEEDLE_CAP; i++) w[i >> 3][(i & 7) * 8 +: 8] = plan_needle[i];
        len_word       = junk ? {$urandom, $urandom} : 64'd0;
        cap_word       = junk ? {$urandom, $urandom} : 64'd0;
        len_word[5:0]  = plan_len;
        cap_word[15:0] = cap;
        write_reg(CFG_NEEDLE_WORD_0, w[0]);
        write_reg(CFG_NEEDLE_WORD_1, w[1]);
        write_reg(CFG_NEEDLE_WORD_2, w[2]);
        write_reg(CFG_NEEDLE_WORD_3, w[3]);
        write_reg(CFG_NEEDLE_LENGTH, len_word);
        write_reg(CFG_RESULT_LIMIT, cap_word);
    endtask

    task automatic pick_needle(input int k);
        int          i;
        logic [15:0] cap;
        for (i = 0; i < NEEDLE_CAP; i++) begin
            plan_needle[i] = ($urandom_range(3) != 0) ? random_letter()
                                                      : 8'($urandom_range(255));
        end
        case (k)
            0: begin plan_len = 6'd0;  cap = 16'd0;      end
            1: begin plan_len = 6'd0;  cap = 16'd1;      end
            2: begin
                for (i = 0; i < NEEDLE_CAP; i++) plan_needle[i] = 8'hFF;
                plan_len = 6'd32;
                cap      = 16'hFFFF;
            end
            3: begin plan_len = 6'd63; cap = 16'hFFFF;   end
            4: begin plan_len = 6'd40; cap = 16'd3;      end
            5: begin
                plan_needle[2] = 8'h00;
                plan_len       = 6'd4;
                cap            = 16'hFFFF;
            end
            6: begin
                for (i = 0; i < NEEDLE_CAP; i++) plan_needle[i] = 8'h00;
                plan_len = 6'd1;
                cap      = 16'd2;
            end
            default: begin
                case ($urandom_range(9))
                    0:       plan_len = 6'($urandom_range(63, 33));
                    1, 2:    plan_len = 6'($urandom_range(32, 6));
                    default: plan_len = 6'($urandom_range(5, 1));
                endcase
                case ($urandom_range(3))
                    0:       cap = 16'($urandom_range(4, 1));
                    1:       cap = 16'hFFFF;
                    2:       cap = 16'($urandom_range(65535));
                    default: cap = 16'($urandom_range(20, 5));
                endcase
            end
        endcase
        load_needle(cap, k > 6);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_gap_pct = 80; recv_stall_pct = 0;  end
            2:       begin send_gap_pct = 0;  recv_stall_pct = 80; end
            default: begin send_gap_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    task automatic settle();
        int waited;
        while (reg_writes.size() != 0 || cfg_valid || char_beats.size() != 0 || s_valid) begin
            @(negedge aclk);
        end
        waited = 0;
        while (match_reports.size() != 0 && waited < REPORT_WAIT) begin
            @(negedge aclk);
            waited++;
        end
        if (match_reports.size() != 0) begin
            note_fault($sformatf("%0d expected reports never arrived", match_reports.size()));
            match_reports.delete();
        end
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    initial begin : stimulus
        int k;
        int e;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_idle(0);
        for (k = 0; k < NEEDLE_CAP; k++) plan_needle[k] = 8'($urandom_range(255));
        plan_needle[0] = "a";
        plan_needle[1] = "B";
        plan_needle[2] = "c";
        plan_len       = 6'd3;
        load_needle(16'hFFFF, 1'b0);
        settle();
        settings_done++;
        push_text("xABC", 1'b0);
        push_text("abd", 1'b0);
        push_beat("a", 1'b0, 1'b0);
        push_beat(8'h00, 1'b0, 1'b0);
        push_beat("b", 1'b0, 1'b0);
        push_beat("c", 1'b1, 1'b0);
        push_beat("a", 1'b0, 1'b1);
        push_text("bc", 1'b0);
        push_beat(8'hFF, 1'b0, 1'b0);
        push_beat("@", 1'b0, 1'b0);
        push_beat("[", 1'b0, 1'b0);
        push_beat("Z", 1'b0, 1'b0);
        push_beat(8'h60, 1'b0, 1'b0);
        push_beat("{", 1'b1, 1'b0);
        push_text("ABC", 1'b1);
        push_text("abc", 1'b1);
        settle();

        for (k = 0; k < RANDOM_SETTINGS; k++) begin
            set_idle(k % 4);
            pick_needle(k);
            settle();
            settings_done++;
            for (e = 0; e < ENTRIES_PER_SETTING; e++) begin
                add_entry(e == ENTRIES_PER_SETTING - 1 || $urandom_range(3) == 0);
            end
            settle();
        end

        $display("Checked %0d match reports from %0d name beats over %0d needle settings",
                 reports_checked, beats_sent, settings_done);
        $display("Covered gap/stall mixes, empty and capped needles, limits 0..65535");
        if (fault_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d faults found", fault_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
